[design/gdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian date counter package
// Field widths, request and response types, operation and status codes, and
// the calendar functions shared by the date counter modules.
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam int KIND_WIDTH        = 3;
   localparam int DAY_WIDTH         = 5;
   localparam int MONTH_WIDTH       = 4;
   localparam int YEAR_WIDTH        = 12;
   localparam int COUNT_FIELD_WIDTH = 12;
   localparam int STATUS_WIDTH      = 2;
   localparam int YEAR_CALC_WIDTH   = 14;

   localparam int LAST_YEAR_DEFAULT   = 4095;
   localparam int COUNT_WIDTH_DEFAULT = 12;

   localparam int FIRST_YEAR  = 1900;
   localparam int CENTURY     = 100;
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_WIDTH  = 27;
   localparam int QUOT_WIDTH  = 8;

   localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_WIDTH-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_WIDTH-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_WIDTH-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_WIDTH-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_WIDTH-1:0] DAY_FIRST  = 5'd1;
   localparam logic [DAY_WIDTH-1:0] DAYS_LONG  = 5'd31;
   localparam logic [DAY_WIDTH-1:0] DAYS_SHORT = 5'd30;
   localparam logic [DAY_WIDTH-1:0] DAYS_LEAP  = 5'd29;
   localparam logic [DAY_WIDTH-1:0] DAYS_FEB   = 5'd28;

   localparam logic [KIND_WIDTH-1:0] KIND_SET       = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_NEXT      = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_PREV      = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_PEEK_FWD  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_PEEK_BACK = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_INVALID = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_LOW     = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_HIGH    = 2'd3;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]        kind;
      logic [DAY_WIDTH-1:0]         new_day;
      logic [MONTH_WIDTH-1:0]       new_month;
      logic [YEAR_WIDTH-1:0]        new_year;
      logic [COUNT_FIELD_WIDTH-1:0] day_count;
   } req_type;

   typedef struct packed {
      logic [DAY_WIDTH-1:0]    out_day;
      logic [MONTH_WIDTH-1:0]  out_month;
      logic [YEAR_WIDTH-1:0]   out_year;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                       back;
      logic [DAY_WIDTH-1:0]       day;
      logic [MONTH_WIDTH-1:0]     month;
      logic [YEAR_CALC_WIDTH-1:0] year;
   } step_req_type;

   typedef struct packed {
      logic                       done;
      logic [STATUS_WIDTH-1:0]    status;
      logic [DAY_WIDTH-1:0]       day;
      logic [MONTH_WIDTH-1:0]     month;
      logic [YEAR_CALC_WIDTH-1:0] year;
   } step_rsp_type;

   function automatic logic is_leap(input logic [YEAR_CALC_WIDTH-1:0] year);
      logic [PROD_WIDTH-1:0]      prod;
      logic [QUOT_WIDTH-1:0]      quot;
      logic [YEAR_CALC_WIDTH-1:0] whole;
      prod  = PROD_WIDTH'(year) * PROD_WIDTH'(RECIP_100);
      quot  = QUOT_WIDTH'(prod >> RECIP_SHIFT);
      whole = YEAR_CALC_WIDTH'(quot) * YEAR_CALC_WIDTH'(CENTURY);
      return (year[1:0] == 2'b00) && ((whole != year) || (quot[1:0] == 2'b00));
   endfunction

   function automatic logic [DAY_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] month,
                                                      input logic leap);
      logic [DAY_WIDTH-1:0] len;
      case (month)
         MONTH_FEB: begin
            len = leap ? DAYS_LEAP : DAYS_FEB;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = DAYS_SHORT;
         end
         default: begin
            len = DAYS_LONG;
         end
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

[design/gdc_month_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date counter month step unit
// One step of a day shift: finishes inside the current month or moves the
// date to the next or previous month boundary, clamping at the calendar ends.
// ----------------------------------------------------------------------------
module gdc_month_unit #(
   parameter int LAST_YEAR = gdc_pkg::LAST_YEAR_DEFAULT,
   parameter int CNT_W     = gdc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  gdc_pkg::step_req_type step_req,
   input  logic [CNT_W-1:0]      step_cnt,
   output gdc_pkg::step_rsp_type step_rsp,
   output logic [CNT_W-1:0]      step_cnt_next
);

   localparam int WW = ((CNT_W > gdc_pkg::DAY_WIDTH) ? CNT_W : gdc_pkg::DAY_WIDTH) + 1;
   localparam int YW = gdc_pkg::YEAR_CALC_WIDTH;

   logic                          leap;
   logic [gdc_pkg::DAY_WIDTH-1:0] len_cur;
   logic [gdc_pkg::DAY_WIDTH-1:0] len_prev;
   logic [WW-1:0]                 cnt_w;
   logic [WW-1:0]                 day_w;
   logic [WW-1:0]                 rest_w;

   assign leap     = gdc_pkg::is_leap(step_req.year);
   assign len_cur  = gdc_pkg::month_len(step_req.month, leap);
   assign len_prev = gdc_pkg::month_len(step_req.month - 4'd1, leap);
   assign cnt_w    = WW'(step_cnt);
   assign day_w    = WW'(step_req.day);
   assign rest_w   = WW'(len_cur - step_req.day);

   always_comb begin
      step_rsp.done   = 1'b0;
      step_rsp.status = gdc_pkg::STAT_OK;
      step_rsp.day    = step_req.day;
      step_rsp.month  = step_req.month;
      step_rsp.year   = step_req.year;
      step_cnt_next   = step_cnt;
      if (cnt_w == '0) begin
         step_rsp.done = 1'b1;
      end else if (!step_req.back) begin
         if (cnt_w <= rest_w) begin
            step_rsp.done = 1'b1;
            step_rsp.day  = gdc_pkg::DAY_WIDTH'(day_w + cnt_w);
         end else begin
            step_cnt_next = CNT_W'(cnt_w - rest_w - WW'(1));
            step_rsp.day  = gdc_pkg::DAY_FIRST;
            if (step_req.month == gdc_pkg::MONTH_DEC) begin
               if (step_req.year >= YW'(LAST_YEAR)) begin
                  step_rsp.done   = 1'b1;
                  step_rsp.status = gdc_pkg::STAT_HIGH;
                  step_rsp.day    = gdc_pkg::DAYS_LONG;
               end else begin
                  step_rsp.year  = step_req.year + YW'(1);
                  step_rsp.month = gdc_pkg::MONTH_JAN;
               end
            end else begin
               step_rsp.month = step_req.month + 4'd1;
            end
         end
      end else begin
         if (cnt_w < day_w) begin
            step_rsp.done = 1'b1;
            step_rsp.day  = gdc_pkg::DAY_WIDTH'(day_w - cnt_w);
         end else begin
            step_cnt_next = CNT_W'(cnt_w - day_w);
            if (step_req.month == gdc_pkg::MONTH_JAN) begin
               if (step_req.year <= YW'(gdc_pkg::FIRST_YEAR)) begin
                  step_rsp.done   = 1'b1;
                  step_rsp.status = gdc_pkg::STAT_LOW;
                  step_rsp.day    = gdc_pkg::DAY_FIRST;
                  step_rsp.month  = gdc_pkg::MONTH_JAN;
                  step_rsp.year   = YW'(gdc_pkg::FIRST_YEAR);
               end else begin
                  step_rsp.year  = step_req.year - YW'(1);
                  step_rsp.month = gdc_pkg::MONTH_DEC;
                  step_rsp.day   = gdc_pkg::DAYS_LONG;
               end
            end else begin
               step_rsp.month = step_req.month - 4'd1;
               step_rsp.day   = len_prev;
            end
         end
      end
   end

endmodule
`default_nettype wire

[design/gregorian_date_counter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian date counter
// Holds a calendar date from 1/1/1900 to 31/12/LAST_YEAR with full leap-year
// rules. Each request sets the date, steps it one day, or reports the date
// shifted by a day count without changing it; an unused kind reports it unchanged.
//
// Requests enter on req_valid/req_stall, one response per request leaves on
// rsp_valid/rsp_stall. A request is taken only while the block is idle;
// req_stall stays high while it works. The shared month step unit handles one
// month per cycle, so a set or an unused kind finishes in its first step, a
// single-day step needs a second step when it crosses a month, and a peek
// steps through every month that it crosses. The response is registered when
// the work ends and the output register is free. The response register frees
// the input side: a new request is taken while a response still waits, and
// the finished request waits while rsp_stall holds the previous one. Reset
// returns the date to 1/1/1900 and empties the block.
// ----------------------------------------------------------------------------
module gregorian_date_counter_unit #(
   parameter int LAST_YEAR   = gdc_pkg::LAST_YEAR_DEFAULT,
   parameter int COUNT_WIDTH = gdc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  gdc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output gdc_pkg::rsp_type rsp_data
);

   localparam int CNT_W = (COUNT_WIDTH < gdc_pkg::COUNT_FIELD_WIDTH) ?
                          COUNT_WIDTH : gdc_pkg::COUNT_FIELD_WIDTH;
   localparam int YW = gdc_pkg::YEAR_CALC_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   gdc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [gdc_pkg::KIND_WIDTH-1:0]  kind_ff, kind_in;
   logic [gdc_pkg::DAY_WIDTH-1:0]   set_day_ff, set_day_in;
   logic [gdc_pkg::MONTH_WIDTH-1:0] set_month_ff, set_month_in;
   logic [gdc_pkg::YEAR_WIDTH-1:0]  set_year_ff, set_year_in;
   logic [gdc_pkg::DAY_WIDTH-1:0]   day_ff, day_in;
   logic [gdc_pkg::MONTH_WIDTH-1:0] month_ff, month_in;
   logic [YW-1:0]                   year_ff, year_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;

   logic [gdc_pkg::DAY_WIDTH-1:0]   cur_day_ff, cur_day_in;
   logic [gdc_pkg::MONTH_WIDTH-1:0] cur_month_ff, cur_month_in;
   logic [gdc_pkg::YEAR_WIDTH-1:0]  cur_year_ff, cur_year_in;

   gdc_pkg::step_req_type step_req;
   gdc_pkg::step_rsp_type step_rsp;
   logic [CNT_W-1:0]      step_cnt_next;

   logic                              accept;
   logic                              out_free;
   logic                              set_ok;
   logic                              res_done;
   logic [gdc_pkg::DAY_WIDTH-1:0]     res_day;
   logic [gdc_pkg::MONTH_WIDTH-1:0]   res_month;
   logic [YW-1:0]                     res_year;
   logic [gdc_pkg::STATUS_WIDTH-1:0]  res_status;
   logic                              commit;
   logic [YW-1:0]                     set_year_w;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign step_req.back  = (kind_ff == gdc_pkg::KIND_PREV) ||
                           (kind_ff == gdc_pkg::KIND_PEEK_BACK);
   assign step_req.day   = day_ff;
   assign step_req.month = month_ff;
   assign step_req.year  = year_ff;

   gdc_month_unit #(
      .LAST_YEAR (LAST_YEAR),
      .CNT_W     (CNT_W)
   ) u_month_unit (
      .step_req      (step_req),
      .step_cnt      (cnt_ff),
      .step_rsp      (step_rsp),
      .step_cnt_next (step_cnt_next)
   );

   assign set_year_w = YW'(set_year_ff);
   assign set_ok = (set_month_ff inside {[gdc_pkg::MONTH_JAN:gdc_pkg::MONTH_DEC]}) &&
                   (set_year_w >= YW'(gdc_pkg::FIRST_YEAR)) &&
                   (set_year_w <= YW'(LAST_YEAR)) &&
                   (set_day_ff >= gdc_pkg::DAY_FIRST) &&
                   (set_day_ff <= gdc_pkg::month_len(set_month_ff,
                                                     gdc_pkg::is_leap(set_year_w)));

   assign commit = (kind_ff == gdc_pkg::KIND_SET) || (kind_ff == gdc_pkg::KIND_NEXT) ||
                   (kind_ff == gdc_pkg::KIND_PREV);

   always_comb begin
      res_done   = 1'b1;
      res_day    = day_ff;
      res_month  = month_ff;
      res_year   = year_ff;
      res_status = gdc_pkg::STAT_OK;
      case (kind_ff)
         gdc_pkg::KIND_SET: begin
            if (set_ok) begin
               res_day   = set_day_ff;
               res_month = set_month_ff;
               res_year  = set_year_w;
            end else begin
               res_status = gdc_pkg::STAT_INVALID;
            end
         end
         gdc_pkg::KIND_NEXT, gdc_pkg::KIND_PREV,
         gdc_pkg::KIND_PEEK_FWD, gdc_pkg::KIND_PEEK_BACK: begin
            res_done   = step_rsp.done;
            res_day    = step_rsp.day;
            res_month  = step_rsp.month;
            res_year   = step_rsp.year;
            res_status = step_rsp.status;
         end
         default: begin
            res_done = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      kind_in      = kind_ff;
      set_day_in   = set_day_ff;
      set_month_in = set_month_ff;
      set_year_in  = set_year_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      cnt_in       = cnt_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in     = ST_RUN;
         kind_in      = req_data.kind;
         set_day_in   = req_data.new_day;
         set_month_in = req_data.new_month;
         set_year_in  = req_data.new_year;
         day_in       = cur_day_ff;
         month_in     = cur_month_ff;
         year_in      = YW'(cur_year_ff);
         if ((req_data.kind == gdc_pkg::KIND_NEXT) || (req_data.kind == gdc_pkg::KIND_PREV)) begin
            cnt_in = CNT_W'(1);
         end else begin
            cnt_in = req_data.day_count[CNT_W-1:0];
         end
      end else if (state_ff == ST_RUN) begin
         if (res_done) begin
            if (out_free) begin
               state_in              = ST_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_day   = res_day;
               rsp_data_in.out_month = res_month;
               rsp_data_in.out_year  = res_year[gdc_pkg::YEAR_WIDTH-1:0];
               rsp_data_in.status    = res_status;
               if (commit) begin
                  cur_day_in   = res_day;
                  cur_month_in = res_month;
                  cur_year_in  = res_year[gdc_pkg::YEAR_WIDTH-1:0];
               end
            end
         end else begin
            day_in   = step_rsp.day;
            month_in = step_rsp.month;
            year_in  = step_rsp.year;
            cnt_in   = step_cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_day_ff   <= gdc_pkg::DAY_FIRST;
         cur_month_ff <= gdc_pkg::MONTH_JAN;
         cur_year_ff  <= gdc_pkg::YEAR_WIDTH'(gdc_pkg::FIRST_YEAR);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      kind_ff      <= kind_in;
      set_day_ff   <= set_day_in;
      set_month_ff <= set_month_in;
      set_year_ff  <= set_year_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      cnt_ff       <= cnt_in;
   end

endmodule
`default_nettype wire

[sim/gregorian_date_counter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date counter testbench
// Drives set, step and peek requests into the date counter and predicts each
// response from a behavioural calendar kept in step with every accepted
// request. Starts with calendar edge cases (limits, leap days, rejected
// dates, unused kinds), then runs randomised request mixes with random
// gaps, receiver stalls, two long receiver hold-offs and drain pauses.
// ----------------------------------------------------------------------------
module gregorian_date_counter_unit_test;

   localparam int LAST_YEAR    = gdc_pkg::LAST_YEAR_DEFAULT;
   localparam int COUNT_MASK   = (1 << gdc_pkg::COUNT_WIDTH_DEFAULT) - 1;
   localparam int RANDOM_ITEMS = 1650;
   localparam int LONG_HOLD    = 300;
   localparam int PRINT_LIMIT  = 100;

   localparam logic [gdc_pkg::KIND_WIDTH-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [gdc_pkg::KIND_WIDTH-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      gdc_pkg::req_type req;
      int               gap;
      bit               drain;
   } planned_request_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   gdc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   gdc_pkg::rsp_type rsp_data;

   planned_request_type request_plan[$];
   gdc_pkg::rsp_type    dates_due[$];

   planned_request_type staged_item;
   bit                  staged;
   int                  gap_left;
   bit                  gap_calm;
   bit                  drain_next;

   logic req_fired;
   logic rsp_fired;
   int   accepted_reqs;
   int   rsp_taken;
   int   item_total;
   int   mismatches;
   int   stall_left;
   int   hold_left;
   int   next_hold;

   int cal_day   = gdc_pkg::DAY_FIRST;
   int cal_month = gdc_pkg::MONTH_JAN;
   int cal_year  = gdc_pkg::FIRST_YEAR;

   int sets_seen;
   int steps_seen;
   int peeks_seen;
   int spare_seen;
   int rejects_seen;
   int lows_seen;
   int highs_seen;

   gregorian_date_counter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit leap_rule(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in(input int m, input int y);
      if (m == gdc_pkg::MONTH_FEB) begin
         return leap_rule(y) ? gdc_pkg::DAYS_LEAP : gdc_pkg::DAYS_FEB;
      end
      if (m == gdc_pkg::MONTH_APR || m == gdc_pkg::MONTH_JUN ||
          m == gdc_pkg::MONTH_SEP || m == gdc_pkg::MONTH_NOV) begin
         return gdc_pkg::DAYS_SHORT;
      end
      return gdc_pkg::DAYS_LONG;
   endfunction

   function automatic logic [gdc_pkg::STATUS_WIDTH-1:0] shift_forward(
         inout int d, inout int m, inout int y, input int n);
      int rest;
      while (n > 0) begin
         rest = days_in(m, y) - d;
         if (n <= rest) begin
            d = d + n;
            return gdc_pkg::STAT_OK;
         end
         n = n - (rest + 1);
         if (m == gdc_pkg::MONTH_DEC) begin
            if (y >= LAST_YEAR) begin
               d = gdc_pkg::DAYS_LONG;
               return gdc_pkg::STAT_HIGH;
            end
            y = y + 1;
            m = gdc_pkg::MONTH_JAN;
         end else begin
            m = m + 1;
         end
         d = gdc_pkg::DAY_FIRST;
      end
      return gdc_pkg::STAT_OK;
   endfunction

   function automatic logic [gdc_pkg::STATUS_WIDTH-1:0] shift_back(
         inout int d, inout int m, inout int y, input int n);
      while (n > 0) begin
         if (n < d) begin
            d = d - n;
            return gdc_pkg::STAT_OK;
         end
         n = n - d;
         if (m == gdc_pkg::MONTH_JAN) begin
            if (y <= gdc_pkg::FIRST_YEAR) begin
               d = gdc_pkg::DAY_FIRST;
               m = gdc_pkg::MONTH_JAN;
               y = gdc_pkg::FIRST_YEAR;
               return gdc_pkg::STAT_LOW;
            end
            y = y - 1;
            m = gdc_pkg::MONTH_DEC;
         end else begin
            m = m - 1;
         end
         d = days_in(m, y);
      end
      return gdc_pkg::STAT_OK;
   endfunction

   // Work out the response to one request and advance the held date.
   function automatic gdc_pkg::rsp_type advance_calendar(input gdc_pkg::req_type r);
      int                               d;
      int                               m;
      int                               y;
      int                               nd;
      int                               nm;
      int                               ny;
      logic [gdc_pkg::STATUS_WIDTH-1:0] st;
      gdc_pkg::rsp_type                 res;
      d  = cal_day;
      m  = cal_month;
      y  = cal_year;
      nd = r.new_day;
      nm = r.new_month;
      ny = r.new_year;
      st = gdc_pkg::STAT_OK;
      case (r.kind)
         gdc_pkg::KIND_SET: begin
            sets_seen++;
            if (nm >= gdc_pkg::MONTH_JAN && nm <= gdc_pkg::MONTH_DEC &&
                ny >= gdc_pkg::FIRST_YEAR && ny <= LAST_YEAR &&
                nd >= gdc_pkg::DAY_FIRST && nd <= days_in(nm, ny)) begin
               d = nd;
               m = nm;
               y = ny;
            end else begin
               st = gdc_pkg::STAT_INVALID;
            end
         end
         gdc_pkg::KIND_NEXT: begin
            steps_seen++;
            st = shift_forward(d, m, y, 1);
         end
         gdc_pkg::KIND_PREV: begin
            steps_seen++;
            st = shift_back(d, m, y, 1);
         end
         gdc_pkg::KIND_PEEK_FWD: begin
            peeks_seen++;
            st = shift_forward(d, m, y, int'(r.day_count) & COUNT_MASK);
         end
         gdc_pkg::KIND_PEEK_BACK: begin
            peeks_seen++;
            st = shift_back(d, m, y, int'(r.day_count) & COUNT_MASK);
         end
         default: begin
            spare_seen++;
         end
      endcase
      if (r.kind == gdc_pkg::KIND_SET || r.kind == gdc_pkg::KIND_NEXT ||
          r.kind == gdc_pkg::KIND_PREV) begin
         cal_day   = d;
         cal_month = m;
         cal_year  = y;
      end
      case (st)
         gdc_pkg::STAT_INVALID: rejects_seen++;
         gdc_pkg::STAT_LOW: lows_seen++;
         gdc_pkg::STAT_HIGH: highs_seen++;
         default: ;
      endcase
      res.out_day   = gdc_pkg::DAY_WIDTH'(d);
      res.out_month = gdc_pkg::MONTH_WIDTH'(m);
      res.out_year  = gdc_pkg::YEAR_WIDTH'(y);
      res.status    = st;
      return res;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [gdc_pkg::YEAR_WIDTH-1:0] got,
                                  input logic [gdc_pkg::YEAR_WIDTH-1:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch on response %0d: %s is %0d, expected %0d",
                  rsp_taken, what, got, want);
      end
      mismatches++;
   endtask

   // Check responses first: a request taken at this edge cannot answer yet.
   always @(posedge clock) begin : check_responses
      gdc_pkg::rsp_type want;
      req_fired <= !reset && req_valid && !req_stall;
      rsp_fired <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (dates_due.size() == 0) begin
               report_mismatch("unexpected response, day", rsp_data.out_day, '0);
            end else begin
               want = dates_due.pop_front();
               if (rsp_data.out_day !== want.out_day) begin
                  report_mismatch("day", rsp_data.out_day, want.out_day);
               end
               if (rsp_data.out_month !== want.out_month) begin
                  report_mismatch("month", rsp_data.out_month, want.out_month);
               end
               if (rsp_data.out_year !== want.out_year) begin
                  report_mismatch("year", rsp_data.out_year, want.out_year);
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", rsp_data.status, want.status);
               end
            end
            rsp_taken++;
         end
         if (req_valid && !req_stall) begin
            dates_due.push_back(advance_calendar(req_data));
            accepted_reqs++;
         end
      end
   end

   // Hold a stalled request; otherwise wait out the gap and offer the next.
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_fired)) begin
         if (!staged && request_plan.size() > 0) begin
            staged_item = request_plan.pop_front();
            staged      = 1'b1;
            gap_left    = staged_item.gap;
         end
         if (staged && gap_left == 0 && !(staged_item.drain && dates_due.size() != 0)) begin
            req_valid <= 1'b1;
            req_data  <= staged_item.req;
            staged     = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) begin
            stall_left = ((rsp_taken % 256) < 48) ? 0 : $urandom_range(0, 8);
         end
         if (accepted_reqs >= next_hold) begin
            hold_left = LONG_HOLD;
            next_hold = next_hold + 860;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_request(input logic [gdc_pkg::KIND_WIDTH-1:0] kind,
                                input logic [gdc_pkg::DAY_WIDTH-1:0] d,
                                input logic [gdc_pkg::MONTH_WIDTH-1:0] m,
                                input logic [gdc_pkg::YEAR_WIDTH-1:0] y,
                                input logic [gdc_pkg::COUNT_FIELD_WIDTH-1:0] cnt);
      planned_request_type p;
      p.req.kind      = kind;
      p.req.new_day   = d;
      p.req.new_month = m;
      p.req.new_year  = y;
      p.req.day_count = cnt;
      p.gap           = gap_calm ? 0 : $urandom_range(0, 8);
      p.drain         = drain_next;
      drain_next      = 1'b0;
      request_plan.push_back(p);
   endtask

   // Bias towards the calendar ends and century years.
   task automatic random_date(output int d, output int m, output int y);
      case ($urandom_range(0, 9))
         0: y = gdc_pkg::FIRST_YEAR + $urandom_range(0, 2);
         1: y = LAST_YEAR - $urandom_range(0, 2);
         2: y = gdc_pkg::CENTURY * $urandom_range(19, 40);
         default: y = $urandom_range(gdc_pkg::FIRST_YEAR, LAST_YEAR);
      endcase
      if ($urandom_range(0, 3) == 0) begin
         m = (y < 2000) ? gdc_pkg::MONTH_JAN : gdc_pkg::MONTH_DEC;
      end else begin
         m = $urandom_range(gdc_pkg::MONTH_JAN, gdc_pkg::MONTH_DEC);
      end
      case ($urandom_range(0, 5))
         0: d = gdc_pkg::DAY_FIRST;
         1: d = days_in(m, y);
         default: d = $urandom_range(gdc_pkg::DAY_FIRST, days_in(m, y));
      endcase
   endtask

   function automatic int random_count();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return COUNT_MASK;
         2, 3, 4: return $urandom_range(0, COUNT_MASK);
         default: return $urandom_range(1, 62);
      endcase
   endfunction

   initial begin
      timeout_guard();
   end

   task automatic timeout_guard();
      #20_000_000;
      $display("simulation failed");
      $finish;
   endtask

   initial begin : stimulus
      int d;
      int m;
      int y;
      int pick;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      req_fired  = 1'b0;
      rsp_fired  = 1'b0;
      staged     = 1'b0;
      gap_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      next_hold  = 40;
      gap_calm   = 1'b0;
      drain_next = 1'b0;

      // calendar limits from the reset date
      queue_request(gdc_pkg::KIND_PREV, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_PEEK_BACK, '1, '1, '1, 12'd4095);
      queue_request(gdc_pkg::KIND_PEEK_FWD, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_PEEK_BACK, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LONG, gdc_pkg::MONTH_DEC, LAST_YEAR, '0);
      queue_request(gdc_pkg::KIND_NEXT, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_PEEK_FWD, '0, '0, '0, 12'd4095);
      queue_request(gdc_pkg::KIND_PEEK_FWD, '0, '0, '0, 12'd1);
      queue_request(gdc_pkg::KIND_PREV, '0, '0, '0, '0);
      // leap days and rejected dates
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LEAP, gdc_pkg::MONTH_FEB, 12'd2000, '0);
      queue_request(gdc_pkg::KIND_NEXT, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LEAP, gdc_pkg::MONTH_FEB, 12'd1900, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LEAP, gdc_pkg::MONTH_FEB, 12'd2100, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LEAP, gdc_pkg::MONTH_FEB, 12'd2004, '0);
      queue_request(gdc_pkg::KIND_PREV, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_SET, '0, 4'd5, 12'd2020, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LONG, gdc_pkg::MONTH_APR, 12'd2020, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAY_FIRST, '0, 12'd2020, '0);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAY_FIRST, 4'd13, 12'd2020, '0);
      queue_request(gdc_pkg::KIND_SET, '1, '1, '0, '1);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAY_FIRST, gdc_pkg::MONTH_JAN, 12'd1899, '0);
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
         queue_request(gdc_pkg::KIND_WIDTH'(k), '1, '1, '1, '1);
      end
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAYS_LONG, gdc_pkg::MONTH_DEC, 12'd1999, '0);
      queue_request(gdc_pkg::KIND_NEXT, '0, '0, '0, '0);
      queue_request(gdc_pkg::KIND_PEEK_BACK, '0, '0, '0, 12'd4095);
      queue_request(gdc_pkg::KIND_SET, gdc_pkg::DAY_FIRST, gdc_pkg::MONTH_JAN,
                    gdc_pkg::FIRST_YEAR, '0);
      queue_request(gdc_pkg::KIND_PEEK_FWD, '0, '0, '0, 12'd4095);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gap_calm = (i % 200) < 40;
         if (i == 0 || i == 800) begin
            drain_next = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            random_date(d, m, y);
            queue_request(gdc_pkg::KIND_SET, d, m, y, $urandom);
         end else if (pick < 20) begin
            queue_request(gdc_pkg::KIND_SET, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 42) begin
            queue_request(gdc_pkg::KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 64) begin
            queue_request(gdc_pkg::KIND_PREV, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 80) begin
            queue_request(gdc_pkg::KIND_PEEK_FWD, $urandom, $urandom, $urandom,
                          random_count());
         end else if (pick < 96) begin
            queue_request(gdc_pkg::KIND_PEEK_BACK, $urandom, $urandom, $urandom,
                          random_count());
         end else begin
            queue_request($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI), $urandom, $urandom,
                          $urandom, $urandom);
         end
      end
      item_total = request_plan.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_reqs != item_total) begin
         @(posedge clock);
      end
      while (dates_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("run covered %0d requests: %0d sets, %0d single-day steps, %0d peeks, %0d unused",
               accepted_reqs, sets_seen, steps_seen, peeks_seen, spare_seen);
      $display("responses flagged: %0d rejected dates, %0d lower limit, %0d upper limit",
               rejects_seen, lows_seen, highs_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
design/gdc_pkg.sv
design/gdc_month_unit.sv
design/gregorian_date_counter_unit.sv
sim/gregorian_date_counter_unit_test.sv
